// ===== rtl/core/swrm_pkg.sv =====
// Shared types and constants of the sliding window rate meter.
package swrm_pkg;

  localparam int TS_W         = 32;
  localparam int COUNT_W      = 7;
  localparam int SUM_W        = TS_W + COUNT_W;
  localparam int RATE_W       = 34;
  localparam int DIVIDEND_W   = 35;
  localparam int DIV_STEPS    = DIVIDEND_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [DIVIDEND_W-1:0] RATE_SCALE    = DIVIDEND_W'(256000000);
  localparam logic [RATE_W-1:0]     RATE_MAX      = '1;
  localparam logic [COUNT_W-1:0]    WINDOW_RESET  = COUNT_W'(10);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_END   = 1'b1
  } command_t;

  typedef struct packed {
    command_t          command;
    logic [TS_W-1:0]   timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_q8;
    logic [COUNT_W-1:0] samples_in_window;
    logic               zero_time_flag;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_UPDATE,
    B_SCALE,
    B_START,
    B_DIVIDE,
    B_EMIT
  } back_state_t;

endpackage

// ===== rtl/core/swrm_queue.sv =====
// Short duration queue between the front and back parts.
module swrm_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [swrm_pkg::TS_W-1:0]   push_data,
  input  logic                        pop,
  output logic [swrm_pkg::TS_W-1:0]   pop_data,
  output swrm_pkg::queue_status_t     status
);

  localparam int PtrW = (swrm_pkg::QUEUE_DEPTH > 1) ? $clog2(swrm_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(swrm_pkg::QUEUE_DEPTH + 1);

  logic [swrm_pkg::TS_W-1:0] entries [swrm_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]           wr_ptr;
  logic [PtrW-1:0]           rd_ptr;
  logic [CntW-1:0]           fill;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(swrm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (fill == CntW'(swrm_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/swrm_front.sv =====
// Front part: accept events, latch start times, queue end-event durations.
module swrm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  swrm_pkg::in_item_t          in_data,
  input  swrm_pkg::queue_status_t     q_status,
  output logic                        push,
  output logic [swrm_pkg::TS_W-1:0]   push_data
);

  logic                      accept;
  logic [swrm_pkg::TS_W-1:0] start_time;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (in_data.command == swrm_pkg::CMD_END);
  // Modular difference: wraps with the timestamp counter.
  assign push_data = in_data.timestamp_us - start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
    end else if (accept && in_data.command == swrm_pkg::CMD_START) begin
      start_time <= in_data.timestamp_us;
    end
  end

endmodule

// ===== rtl/core/swrm_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module swrm_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [swrm_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [swrm_pkg::SUM_W-1:0]        divisor,
  output logic                              busy,
  output logic [swrm_pkg::DIVIDEND_W-1:0]   quotient
);

  logic [swrm_pkg::SUM_W-1:0]     rem;
  logic [swrm_pkg::SUM_W-1:0]     dvsr;
  logic [swrm_pkg::DIV_CNT_W-1:0] steps_left;
  logic [swrm_pkg::SUM_W:0]       trial;
  logic [swrm_pkg::SUM_W:0]       diff;
  logic                           fits;

  assign trial = {rem, quotient[swrm_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      steps_left <= '0;
    end else if (start) begin
      busy       <= 1'b1;
      steps_left <= swrm_pkg::DIV_CNT_W'(swrm_pkg::DIV_STEPS);
    end else if (busy) begin
      steps_left <= steps_left - 1'b1;
      busy       <= (steps_left != swrm_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[swrm_pkg::SUM_W-1:0] : trial[swrm_pkg::SUM_W-1:0];
      quotient <= {quotient[swrm_pkg::DIVIDEND_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/swrm_back.sv =====
// Back part: duration ring, running sum, rate division and result register.
module swrm_back #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [swrm_pkg::COUNT_W-1:0]    cfg_data,
  input  swrm_pkg::queue_status_t         q_status,
  output logic                            pop,
  input  logic [swrm_pkg::TS_W-1:0]       pop_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output swrm_pkg::out_item_t             out_data
);

  localparam int IW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AW     = ((IW > swrm_pkg::COUNT_W) ? IW : swrm_pkg::COUNT_W) + 1;
  localparam int MaxLen = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;

  swrm_pkg::back_state_t state, state_next;

  logic [swrm_pkg::TS_W-1:0]       ring [MAX_WINDOW];
  logic [swrm_pkg::COUNT_W-1:0]    window_length;
  logic [IW-1:0]                   head;
  logic [swrm_pkg::COUNT_W-1:0]    count;
  logic [swrm_pkg::SUM_W-1:0]      window_sum;
  logic [swrm_pkg::TS_W-1:0]       dur;
  logic [swrm_pkg::TS_W-1:0]       oldest;
  logic [swrm_pkg::DIVIDEND_W-1:0] dividend;
  logic                            zero_sum;

  logic [swrm_pkg::COUNT_W-1:0]    eff_len;
  logic                            drop;
  logic [IW-1:0]                   head_next;
  logic [swrm_pkg::COUNT_W-1:0]    count_kept;
  logic [AW-1:0]                   wr_pos;
  logic [IW-1:0]                   wr_addr;
  logic [swrm_pkg::SUM_W-1:0]      sum_next;

  logic                            div_start;
  logic                            div_busy;
  logic [swrm_pkg::DIVIDEND_W-1:0] quotient;
  logic                            out_load;
  swrm_pkg::out_item_t             result;

  swrm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (window_sum),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Clamp the programmed length into 1..MaxLen.
  always_comb begin
    if (window_length == '0) begin
      eff_len = swrm_pkg::COUNT_W'(1);
    end else if (window_length > swrm_pkg::COUNT_W'(MaxLen)) begin
      eff_len = swrm_pkg::COUNT_W'(MaxLen);
    end else begin
      eff_len = window_length;
    end
  end

  // Count never exceeds the length, so at most one entry drops per item.
  always_comb begin
    drop       = (count >= eff_len);
    head_next  = head;
    count_kept = count;
    if (drop) begin
      head_next  = (head == IW'(MAX_WINDOW - 1)) ? '0 : head + 1'b1;
      count_kept = count - 1'b1;
    end
    wr_pos = AW'(head_next) + AW'(count_kept);
    if (wr_pos >= AW'(MAX_WINDOW)) begin
      wr_pos = wr_pos - AW'(MAX_WINDOW);
    end
    wr_addr  = wr_pos[IW-1:0];
    sum_next = window_sum - (drop ? swrm_pkg::SUM_W'(oldest) : '0)
               + swrm_pkg::SUM_W'(dur);
  end

  always_comb begin
    result.samples_in_window = count;
    result.zero_time_flag    = zero_sum;
    if (zero_sum || quotient[swrm_pkg::DIVIDEND_W-1]) begin
      result.rate_q8 = swrm_pkg::RATE_MAX;
    end else begin
      result.rate_q8 = quotient[swrm_pkg::RATE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      swrm_pkg::B_IDLE:   if (!q_status.empty) state_next = swrm_pkg::B_READ;
      swrm_pkg::B_READ:   state_next = swrm_pkg::B_UPDATE;
      swrm_pkg::B_UPDATE: state_next = swrm_pkg::B_SCALE;
      swrm_pkg::B_SCALE: begin
        state_next = (window_sum == '0) ? swrm_pkg::B_EMIT : swrm_pkg::B_START;
      end
      swrm_pkg::B_START:  state_next = swrm_pkg::B_DIVIDE;
      swrm_pkg::B_DIVIDE: if (!div_busy) state_next = swrm_pkg::B_EMIT;
      swrm_pkg::B_EMIT:   if (!out_valid || !out_stall) state_next = swrm_pkg::B_IDLE;
      default:            state_next = swrm_pkg::B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      swrm_pkg::B_IDLE:   pop = !q_status.empty;
      swrm_pkg::B_START:  div_start = 1'b1;
      swrm_pkg::B_EMIT:   out_load = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= swrm_pkg::B_IDLE;
      window_length <= swrm_pkg::WINDOW_RESET;
      head          <= '0;
      count         <= '0;
      window_sum    <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        window_length <= cfg_data;
        head          <= '0;
        count         <= '0;
        window_sum    <= '0;
      end else if (state == swrm_pkg::B_UPDATE) begin
        head       <= head_next;
        count      <= count_kept + 1'b1;
        window_sum <= sum_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dur <= pop_data;
    end
    if (state == swrm_pkg::B_SCALE) begin
      dividend <= swrm_pkg::DIVIDEND_W'(count) * swrm_pkg::RATE_SCALE;
      zero_sum <= (window_sum == '0);
    end
    if (out_load) begin
      out_data <= result;
    end
  end

  // Ring storage: oldest entry read in the cycle before the update.
  always_ff @(posedge clk) begin
    if (state == swrm_pkg::B_READ) begin
      oldest <= ring[head];
    end
    if (state == swrm_pkg::B_UPDATE) begin
      ring[wr_addr] <= dur;
    end
  end

endmodule

// ===== rtl/core/sliding_window_rate_meter.sv =====
// Top level of the sliding window rate meter.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   in      | request   | in_valid / in_stall | in_data  (command, timestamp_us)
//   out     | result    | out_valid/out_stall | out_data (rate_q8, samples,flag)
//   cfg     | write     | cfg_write           | cfg_data (window_length)
//
// A start request only latches its timestamp in the front part and gives no result.
// An end request holds the back part through pop, ring read, update, scale,
// divider start, the 35-step restoring divider that forms count * 256e6 / sum,
// and the result load; a zero sum skips the divider.
// Up to two end-request durations wait in the queue while the back part works.
// Reset is synchronous; the ring needs no clearing pass, only held entries are read.
// A stalled result holds in the output register; the back part then waits
// with the next result, and in_stall rises once the queue is full.
module sliding_window_rate_meter #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swrm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swrm_pkg::out_item_t           out_data,
  input  logic                          cfg_write,
  input  logic [swrm_pkg::COUNT_W-1:0]  cfg_data
);

  // Durations handed from front to back.
  logic                      push;
  logic [swrm_pkg::TS_W-1:0] push_data;
  logic                      pop;
  logic [swrm_pkg::TS_W-1:0] pop_data;
  swrm_pkg::queue_status_t   q_status;

  // Front: latch start times, turn end requests into durations.
  swrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple front and back so each stalls on its own.
  swrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Back: advance the window, divide, hold the result until taken.
  swrm_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/swrm_checker.sv =====
// Port-level checks of the sliding window rate meter, bound to the top level.
module swrm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input swrm_pkg::in_item_t            in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input swrm_pkg::out_item_t           out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_zero_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_time_flag |-> out_data.rate_q8 == swrm_pkg::RATE_MAX)
    else $error("zero time flag without saturated rate");

  a_samples_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.samples_in_window != '0)
    else $error("result with empty window");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sliding_window_rate_meter swrm_checker u_swrm_checker (.*);

// ===== sim/swrm_rate_checker.sv =====
// Checker that predicts the rate meter's readings and compares them on the result channel.
`timescale 1ns / 100ps

module swrm_rate_checker #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  swrm_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  swrm_pkg::out_item_t           out_data,
  input  logic                          cfg_write,
  input  logic [swrm_pkg::COUNT_W-1:0]  cfg_data,
  output int unsigned                   failures,
  output int unsigned                   pending
);

  localparam logic [63:0] HZ_Q8_SCALE  = 64'd256000000;
  localparam int unsigned EXPECT_DEPTH = 16;

  logic [swrm_pkg::COUNT_W-1:0] window_reg;
  logic [swrm_pkg::TS_W-1:0]    open_start;
  logic [swrm_pkg::TS_W-1:0]    durations [MAX_WINDOW];
  int unsigned                  oldest;
  int unsigned                  held;
  logic [swrm_pkg::SUM_W-1:0]   total_us;
  swrm_pkg::out_item_t          expected_readings [EXPECT_DEPTH];
  int unsigned                  expect_wr;
  int unsigned                  expect_rd;
  int unsigned                  expect_count;

  // Clamp the raw register to the usable window size.
  function automatic int unsigned window_span();
    if (window_reg == 0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return window_reg;
  endfunction

  task automatic log_interval(input logic [swrm_pkg::TS_W-1:0] stamp);
    logic [swrm_pkg::TS_W-1:0] span_us;
    logic [63:0]               hz_q8;
    swrm_pkg::out_item_t       reading;
    span_us = stamp - open_start;
    // drop the oldest durations until the new one fits
    while (held >= window_span() && held > 0) begin
      total_us = total_us - swrm_pkg::SUM_W'(durations[oldest]);
      oldest = (oldest + 1) % MAX_WINDOW;
      held--;
    end
    durations[(oldest + held) % MAX_WINDOW] = span_us;
    held++;
    total_us = total_us + swrm_pkg::SUM_W'(span_us);
    reading.samples_in_window = swrm_pkg::COUNT_W'(held);
    if (total_us == 0) begin
      reading.rate_q8        = swrm_pkg::RATE_MAX;
      reading.zero_time_flag = 1'b1;
    end else begin
      hz_q8 = (64'(held) * HZ_Q8_SCALE) / 64'(total_us);
      reading.rate_q8        = (hz_q8 > 64'(swrm_pkg::RATE_MAX)) ? swrm_pkg::RATE_MAX
                                                                 : hz_q8[swrm_pkg::RATE_W-1:0];
      reading.zero_time_flag = 1'b0;
    end
    if (expect_count == EXPECT_DEPTH) begin
      $display("%0t: reading backlog full, expected rate_q8=%0d lost",
               $time, reading.rate_q8);
      failures++;
    end else begin
      expected_readings[expect_wr] = reading;
      expect_wr = (expect_wr + 1) % EXPECT_DEPTH;
      expect_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    swrm_pkg::out_item_t want;
    if (rst) begin
      window_reg   = swrm_pkg::WINDOW_RESET;
      open_start   = '0;
      oldest       = 0;
      held         = 0;
      total_us     = '0;
      failures     = 0;
      expect_wr    = 0;
      expect_rd    = 0;
      expect_count = 0;
    end else begin
      if (cfg_write) begin
        window_reg = cfg_data;
        oldest     = 0;
        held       = 0;
        total_us   = '0;
      end
      if (out_valid && !out_stall) begin
        if (expect_count == 0) begin
          $display("%0t: reading with none expected: rate_q8=%0d samples=%0d flag=%0b",
                   $time, out_data.rate_q8, out_data.samples_in_window,
                   out_data.zero_time_flag);
          failures++;
        end else begin
          want = expected_readings[expect_rd];
          expect_rd = (expect_rd + 1) % EXPECT_DEPTH;
          expect_count--;
          if (out_data !== want) begin
            failures++;
            if (out_data.rate_q8 !== want.rate_q8)
              $display("%0t: rate_q8 expected %0d actual %0d",
                       $time, want.rate_q8, out_data.rate_q8);
            if (out_data.samples_in_window !== want.samples_in_window)
              $display("%0t: samples_in_window expected %0d actual %0d",
                       $time, want.samples_in_window, out_data.samples_in_window);
            if (out_data.zero_time_flag !== want.zero_time_flag)
              $display("%0t: zero_time_flag expected %0b actual %0b",
                       $time, want.zero_time_flag, out_data.zero_time_flag);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == swrm_pkg::CMD_START) open_start = in_data.timestamp_us;
        else log_interval(in_data.timestamp_us);
      end
    end
    pending = expect_count;
  end

endmodule

// ===== sim/tb_sliding_window_rate_meter.sv =====
// Stimulus and verdict for the sliding window rate meter, checked by swrm_rate_checker.
`timescale 1ns / 100ps

module tb_sliding_window_rate_meter;

  // Receiver hold-off long enough to fill the block's queue and raise in_stall.
  localparam int HOLD_OFF_CYCLES = 400;
  // Idle time before a register write; covers one full divide in the back part.
  localparam int SETTLE_CYCLES   = 60;
  // Cycles with no request or result moving before the run is declared hung.
  localparam int STALL_LIMIT     = 4000;
  // Requests per stretch of one idling mode (busy or back-to-back).
  localparam int QUIET_RUN       = 24;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  swrm_pkg::in_item_t           in_data;
  logic                         out_valid;
  logic                         out_stall;
  swrm_pkg::out_item_t          out_data;
  logic                         cfg_write;
  logic [swrm_pkg::COUNT_W-1:0] cfg_data;

  int unsigned        failures;
  int unsigned        pending;
  int unsigned        idle_cycles = 0;
  int unsigned        in_sent;
  logic               in_quiet;
  logic               long_hold_req;

  // Window settings per phase, extremes first; slot six gets a random value.
  logic [swrm_pkg::COUNT_W-1:0] window_plan [8] =
    '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd33, 7'd10};
  int unsigned        phase_items [8] = '{90, 200, 80, 180, 100, 90, 100, 90};

  sliding_window_rate_meter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  swrm_rate_checker rate_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quiet stretches run back to back; otherwise wait a random gap.
  function automatic int unsigned draw_gap(input logic quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Mix tiny, zero, mid-range and near-wrap durations.
  function automatic logic [swrm_pkg::TS_W-1:0] draw_duration();
    case ($urandom_range(0, 9))
      0:          return '0;
      1, 2, 3, 4: return swrm_pkg::TS_W'($urandom_range(1, 20));
      5, 6, 7:    return swrm_pkg::TS_W'($urandom_range(1000, 2000000));
      8:          return swrm_pkg::TS_W'($urandom);
      default:    return 32'hFFFF_FFFF - swrm_pkg::TS_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic offer(input swrm_pkg::command_t cmd,
                       input logic [swrm_pkg::TS_W-1:0] stamp);
    int unsigned gap;
    if (in_sent % QUIET_RUN == 0) in_quiet = ($urandom_range(0, 3) == 0);
    in_sent++;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{command: cmd, timestamp_us: stamp};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding reading, then let the back part drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [swrm_pkg::COUNT_W-1:0] length);
    settle();
    cfg_data  <= length;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly start/end pairs with random content, sometimes a repeated end,
  // and a fifth of the time a lone request of random kind.
  task automatic run_phase(input int unsigned items);
    int unsigned               done;
    int unsigned               pick;
    logic [swrm_pkg::TS_W-1:0] mark;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        mark = swrm_pkg::TS_W'($urandom);
        offer(swrm_pkg::CMD_START, mark);
        offer(swrm_pkg::CMD_END, mark + draw_duration());
        done += 2;
        if (pick == 0) begin
          offer(swrm_pkg::CMD_END, mark + draw_duration());
          done++;
        end
      end else begin
        offer(swrm_pkg::command_t'($urandom_range(0, 1)), swrm_pkg::TS_W'($urandom));
        done++;
      end
    end
  endtask

  // Receiver: stall each result for a random count of cycles once it shows up;
  // once per run, when asked, hold off for a long stretch regardless of valid.
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    logic        quiet;
    logic        long_hold_taken;
    out_stall       = 1'b0;
    taken           = 0;
    quiet           = 1'b0;
    long_hold_taken = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (taken % QUIET_RUN == 0) quiet = ($urandom_range(0, 3) == 0);
      taken++;
      gap = draw_gap(quiet);
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (gap > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    long_hold_req = 1'b0;
    in_sent       = 0;
    in_quiet      = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at the reset window of ten.
    // End with no start measures from zero; two zero durations give a zero sum.
    offer(swrm_pkg::CMD_END, 32'd0);
    offer(swrm_pkg::CMD_END, 32'd0);
    offer(swrm_pkg::CMD_END, 32'd5);
    // Back-to-back starts: the later one wins.
    offer(swrm_pkg::CMD_START, 32'hFFFF_FFFF);
    offer(swrm_pkg::CMD_START, 32'd100);
    offer(swrm_pkg::CMD_END, 32'd150);
    // Repeated end from the same start, wrapping below it.
    offer(swrm_pkg::CMD_END, 32'd0);
    // Timestamp wrap across zero.
    offer(swrm_pkg::CMD_START, 32'hFFFF_FFF0);
    offer(swrm_pkg::CMD_END, 32'h0000_0010);
    // Longest duration, then the largest forward span.
    offer(swrm_pkg::CMD_START, 32'd1);
    offer(swrm_pkg::CMD_END, 32'd0);
    offer(swrm_pkg::CMD_START, 32'd0);
    offer(swrm_pkg::CMD_END, 32'hFFFF_FFFF);
    // Alternating bit patterns in both directions.
    offer(swrm_pkg::CMD_START, 32'hAAAA_AAAA);
    offer(swrm_pkg::CMD_END, 32'h5555_5555);
    offer(swrm_pkg::CMD_START, 32'h5555_5555);
    offer(swrm_pkg::CMD_END, 32'hAAAA_AAAA);
    // Two more ends than the window holds, so the oldest get evicted.
    offer(swrm_pkg::CMD_START, 32'd0);
    offer(swrm_pkg::CMD_END, 32'd1);
    offer(swrm_pkg::CMD_END, 32'd1);

    // Random phases, each under its own window setting.
    window_plan[6] = swrm_pkg::COUNT_W'($urandom_range(3, 63));
    foreach (window_plan[p]) begin
      write_window(window_plan[p]);
      // Fill the queue under the widest window: hold the receiver off for a while.
      if (p == 1) long_hold_req = 1'b1;
      run_phase(phase_items[p]);
    end

    settle();
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
